[src/ttdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdd_pkg
// Shared types and constants for the tilt to differential drive block.
// ----------------------------------------------------------------------------
package ttdd_pkg;

  // Q1.16 unsigned fixed point
  localparam int unsigned QW = 17;
  localparam logic [QW-1:0] QOne  = 17'd65536;
  localparam logic [QW-1:0] QHalf = 17'd32768;

  // input clamp limits
  localparam logic signed [15:0] XClamp = 16'sd255;
  localparam logic signed [15:0] YClamp = 16'sd180;

  // yq = 182*v + floor((4*v + 45) / 90), v in [0,360]
  localparam logic [7:0]  YStep    = 8'd182;
  localparam logic [10:0] YBias    = 11'd45;
  localparam logic [11:0] YRecip90 = 12'd2913;   // ceil(2^18 / 90)
  localparam int unsigned YRecipSh = 18;

  // register map, word index
  typedef enum logic [1:0] {
    CfgFwdSpeed = 2'd0,
    CfgRevSpeed = 2'd1,
    CfgRevThr   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [QW-1:0] fwd_speed;
    logic [QW-1:0] rev_speed;
    logic [QW-1:0] rev_thr;
  } cfg_t;

  // front half to back half of the pipeline
  typedef struct packed {
    logic          valid;
    logic          x_pos;   // tilt to the right: steer the right wheel
    logic          y_low;   // scaled y below one half
    logic [29:0]   y_sq;    // yq^2, Q0.32 (used when y_low)
    logic [15:0]   one_my;  // 1 - yq (used when !y_low)
    logic [QW-1:0] x4;      // x^4, Q1.16
  } norm_t;

endpackage

[src/ttdd_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdd_regs
// APB register file: forward speed, reverse speed, reverse threshold.
// ----------------------------------------------------------------------------
module ttdd_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ttdd_pkg::cfg_t      cfg_o
);
  import ttdd_pkg::*;

  logic [QW-1:0] fwd_q, fwd_d;
  logic [QW-1:0] rev_q, rev_d;
  logic [QW-1:0] thr_q, thr_d;
  logic [QW-1:0] wval;
  logic          wr_en;
  cfg_idx_e      idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = cfg_idx_e'(paddr[3:2]);
  // values above one in pwdata[16:0] saturate; upper bits are ignored
  assign wval   = (pwdata[QW-1:0] > QOne) ? QOne : pwdata[QW-1:0];

  always_comb begin
    fwd_d = fwd_q;
    rev_d = rev_q;
    thr_d = thr_q;
    if (wr_en) begin
      unique case (idx)
        CfgFwdSpeed: fwd_d = wval;
        CfgRevSpeed: rev_d = wval;
        CfgRevThr:   thr_d = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CfgFwdSpeed: prdata = {15'd0, fwd_q};
      CfgRevSpeed: prdata = {15'd0, rev_q};
      CfgRevThr:   prdata = {15'd0, thr_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 17'd45875;
      rev_q <= 17'd52429;
      thr_q <= 17'd6554;
    end else begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
      thr_q <= thr_d;
    end
  end

  assign cfg_o.fwd_speed = fwd_q;
  assign cfg_o.rev_speed = rev_q;
  assign cfg_o.rev_thr   = thr_q;

endmodule

[src/ttdd_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdd_norm
// Stages 1-3: clamp and scale the tilt, square y, raise x to the fourth.
// ----------------------------------------------------------------------------
module ttdd_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  output ttdd_pkg::norm_t    norm_o
);
  import ttdd_pkg::*;

  // stage 1: clamp, |x| scale
  logic signed [15:0] ax_c, ay_c;
  logic [7:0]         axm;
  logic [QW-1:0]      xm_d;
  logic [8:0]         v_d;
  logic               s1_vld_q, s1_xpos_q;
  logic [QW-1:0]      s1_xm_q;
  logic [8:0]         s1_v_q;

  always_comb begin
    if (accel_x_i > XClamp)       ax_c = XClamp;
    else if (accel_x_i < -XClamp) ax_c = -XClamp;
    else                          ax_c = accel_x_i;
    if (accel_y_i > YClamp)       ay_c = YClamp;
    else if (accel_y_i < -YClamp) ay_c = -YClamp;
    else                          ay_c = accel_y_i;
    axm  = ax_c[15] ? 8'(-ax_c) : ax_c[7:0];
    // round(|ax| * 65536 / 255) = 257*|ax| + (|ax| >= 128)
    xm_d = {1'b0, axm, 8'd0} + {9'd0, axm} + {16'd0, axm[7]};
    v_d  = 9'(ay_c + YClamp);
  end

  // stage 2: y scale, x^2
  logic [10:0]   n2;
  logic [22:0]   qprod;
  logic [33:0]   xsq_p;
  logic [QW-1:0] yq_d, xsq_d;
  logic          s2_vld_q, s2_xpos_q;
  logic [QW-1:0] s2_yq_q, s2_xsq_q;

  always_comb begin
    n2    = {s1_v_q, 2'b00} + YBias;
    qprod = 23'(n2) * 23'(YRecip90);
    yq_d  = 17'(s1_v_q) * 17'(YStep) + 17'(qprod[22:YRecipSh]);
    xsq_p = 34'(s1_xm_q) * 34'(s1_xm_q) + 34'(QHalf);
    xsq_d = xsq_p[32:16];
  end

  // stage 3: y^2, 1 - y, x^4
  logic [33:0]   x4_p;
  logic [QW-1:0] omy_full;
  norm_t         s3_d, s3_q;
  logic          s3_vld_q;

  always_comb begin
    x4_p          = 34'(s2_xsq_q) * 34'(s2_xsq_q) + 34'(QHalf);
    omy_full      = QOne - s2_yq_q;
    s3_d.valid    = s2_vld_q;
    s3_d.x_pos    = s2_xpos_q;
    s3_d.y_low    = (s2_yq_q[16:15] == 2'b00);
    s3_d.y_sq     = 30'(s2_yq_q[14:0]) * 30'(s2_yq_q[14:0]);
    s3_d.one_my   = omy_full[15:0];
    s3_d.x4       = x4_p[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s3_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_xpos_q   <= (ax_c > 16'sd0);
    s1_xm_q     <= xm_d;
    s1_v_q      <= v_d;
    s2_xpos_q   <= s1_xpos_q;
    s2_yq_q     <= yq_d;
    s2_xsq_q    <= xsq_d;
    s3_q        <= s3_d;
  end

  // valid comes from the reset flop, data from the plain one
  always_comb begin
    norm_o       = s3_q;
    norm_o.valid = s3_vld_q;
  end

endmodule

[src/ttdd_drive.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttdd_drive
// Stages 4-6: speed curve, reverse select, wheel scaling.
// ----------------------------------------------------------------------------
module ttdd_drive (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ttdd_pkg::cfg_t  cfg_i,
  input  ttdd_pkg::norm_t norm_i,
  output logic            done_o,
  output logic [16:0]     left_drive_o,
  output logic [16:0]     right_drive_o,
  output logic            reverse_flag_o
);
  import ttdd_pkg::*;

  // stage 4: raw speed, steering ratio
  logic [46:0]   lo_p;
  logic [17:0]   c_fac;
  logic [33:0]   hi_p;
  logic [17:0]   drop;
  logic [QW-1:0] spd_lo, spd_hi, spd_d, ratio_d;
  logic          s4_vld_q, s4_xpos_q;
  logic [QW-1:0] s4_spd_q, s4_ratio_q;

  always_comb begin
    lo_p    = 47'(cfg_i.fwd_speed) * 47'(norm_i.y_sq) + 47'(1) * 47'(2**29);
    spd_lo  = lo_p[46:30];
    c_fac   = {QOne - cfg_i.fwd_speed, 1'b0};
    hi_p    = 34'(c_fac) * 34'(norm_i.one_my) + 34'(QHalf);
    drop    = hi_p[33:16];
    spd_hi  = (drop >= 18'(QOne)) ? 17'd0 : 17'(18'(QOne) - drop);
    spd_d   = norm_i.y_low ? spd_lo : spd_hi;
    ratio_d = QOne - norm_i.x4;
  end

  // stage 5: reverse select, per-wheel ratio
  logic          rev_d;
  logic          s5_vld_q, s5_rev_q;
  logic [QW-1:0] s5_spd_q, s5_lr_q, s5_rr_q;

  assign rev_d = (s4_spd_q < cfg_i.rev_thr);

  // stage 6: drive = speed * ratio
  logic [33:0] l_p, r_p;
  logic        out_vld_q, out_rev_q;
  logic [QW-1:0] out_l_q, out_r_q;

  always_comb begin
    l_p = 34'(s5_spd_q) * 34'(s5_lr_q) + 34'(QHalf);
    r_p = 34'(s5_spd_q) * 34'(s5_rr_q) + 34'(QHalf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s4_vld_q  <= norm_i.valid;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_xpos_q  <= norm_i.x_pos;
    s4_spd_q   <= spd_d;
    s4_ratio_q <= ratio_d;
    s5_rev_q   <= rev_d;
    s5_spd_q   <= rev_d ? cfg_i.rev_speed : s4_spd_q;
    s5_lr_q    <= s4_xpos_q ? QOne : s4_ratio_q;
    s5_rr_q    <= s4_xpos_q ? s4_ratio_q : QOne;
    out_l_q    <= l_p[32:16];
    out_r_q    <= r_p[32:16];
    out_rev_q  <= s5_rev_q;
  end

  assign done_o         = out_vld_q;
  assign left_drive_o   = out_l_q;
  assign right_drive_o  = out_r_q;
  assign reverse_flag_o = out_rev_q;

endmodule

[src/tilt_to_differential_drive.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_to_differential_drive
// Maps one accelerometer tilt sample to left/right motor duty (Q1.16).
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ----------------------------
// sample    in         start & !busy                accel_x_i, accel_y_i
// result    out        done_o (one cycle, no stall) left/right_drive_o,
//                                                   reverse_flag_o
// config    in/out     APB psel/penable/pwrite      paddr, pwdata, prdata
//
// Pipeline: six stages, one transaction per cycle. An accepted sample is
//   registered through stages 1-3 in ttdd_norm and 4-6 in ttdd_drive.
//   Depth is set by the multiplier chain: x^2 -> x^4 on the steering side,
//   y^2 -> fwd*y^2 on the speed side, then speed*ratio.
// Reset: rst_ni clears the valid bits and loads the register defaults
//   (0.7 forward, 0.8 reverse, 0.1 threshold). Data registers are not reset.
// Stalls: none. busy is held low; the receiver takes every result.
// ----------------------------------------------------------------------------
module tilt_to_differential_drive (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample transaction
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  // result transaction
  output logic               done_o,
  output logic [16:0]        left_drive_o,
  output logic [16:0]        right_drive_o,
  output logic               reverse_flag_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ttdd_pkg::*;

  cfg_t  cfg;
  norm_t norm;
  logic  accept;

  // fully pipelined, so a new sample is always welcome
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // register file
  ttdd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stages 1-3: clamp/scale, x^2 and y scale, x^4 and y^2
  ttdd_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (accept),
    .accel_x_i (accel_x_i),
    .accel_y_i (accel_y_i),
    .norm_o    (norm)
  );

  // stages 4-6: speed curve, reverse select, wheel scaling
  ttdd_drive u_drive (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .norm_i         (norm),
    .done_o         (done_o),
    .left_drive_o   (left_drive_o),
    .right_drive_o  (right_drive_o),
    .reverse_flag_o (reverse_flag_o)
  );

  // every accepted sample yields a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("result missing six cycles after accept");

  // no result without a matching sample
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 6))
    else $error("result without a matching sample");

  // in reverse both wheels run at or below the reverse speed
  a_rev_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && reverse_flag_o) |->
      (left_drive_o <= cfg.rev_speed && right_drive_o <= cfg.rev_speed))
    else $error("reverse drive exceeds reverse speed");

endmodule
